### design/ofcc_pkg.sv
// ----------------------------------------------------------------------------
// ofcc_pkg
// Types, codes and the CRC-8 constant shared by the 1-Wire frame checker.
// ----------------------------------------------------------------------------
package ofcc_pkg;

	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [3:0] ROM_LEN  = 4'd7;
	localparam logic [3:0] PAD_LEN  = 4'd8;
	localparam int         PADDR_W  = 3;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_CRC_ERR = 2'd1,
		STATUS_NO_DEV  = 2'd2
	} status_t;

	typedef enum logic {
		CMD_BUS_RESET = 1'b0,
		CMD_DATA      = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_FRAME_KIND = 1'b0,
		REG_UNUSED     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       present;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         dev_family;
		logic [47:0]        dev_serial;
		logic signed [15:0] temperature_raw;
		logic signed [15:0] previous_temperature;
		logic [7:0]         resolution_config;
		logic [7:0]         crc_errors;
	} out_item_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} step_res_t;

endpackage

### design/ofcc_crc8.sv
// ----------------------------------------------------------------------------
// ofcc_crc8
// One byte of the reflected CRC-8, LSB first, polynomial 0x8C.
// ----------------------------------------------------------------------------
module ofcc_crc8 (
	input  logic [7:0] crc,
	input  logic [7:0] data_byte,
	output logic [7:0] crc_next
);
	import ofcc_pkg::*;

	always_comb begin
		logic [7:0] c;
		c = crc ^ data_byte;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_next = c;
	end

endmodule

### design/ofcc_frame_core.sv
// ----------------------------------------------------------------------------
// ofcc_frame_core
// Frame state, byte buffer and stored sensor values; works one request per
// step and gives the result that the request causes, if any.
// ----------------------------------------------------------------------------
module ofcc_frame_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                frame_kind,
	input  ofcc_pkg::in_item_t  item,
	output ofcc_pkg::step_res_t res
);
	import ofcc_pkg::*;

	logic [7:0]  crc_q, crc_d, crc_new;
	logic [3:0]  idx_q, idx_d, len;
	logic        active_q, active_d;
	logic [7:0]  buf_q [8];
	logic        buf_wr;
	logic [7:0]  family_q, family_d;
	logic [47:0] serial_q, serial_d;
	logic [7:0]  config_q, config_d;
	logic [15:0] temp_q, temp_d;
	logic [15:0] prior_q, prior_d;
	logic [7:0]  fail_q, fail_d;
	logic        emit;
	logic [1:0]  status;

	ofcc_crc8 u_crc (
		.crc       (crc_q),
		.data_byte (item.data_byte),
		.crc_next  (crc_new)
	);

	assign len = frame_kind ? PAD_LEN : ROM_LEN;

	always_comb begin
		crc_d    = crc_q;
		idx_d    = idx_q;
		active_d = active_q;
		family_d = family_q;
		serial_d = serial_q;
		config_d = config_q;
		temp_d   = temp_q;
		prior_d  = prior_q;
		fail_d   = fail_q;
		buf_wr   = 1'b0;
		emit     = 1'b0;
		status   = STATUS_OK;
		if (item.cmd == CMD_BUS_RESET) begin
			crc_d    = '0;
			idx_d    = '0;
			active_d = item.present;
			if (!item.present) begin
				emit   = 1'b1;
				status = STATUS_NO_DEV;
			end
		end else if (active_q) begin
			if (idx_q < len) begin
				buf_wr = 1'b1;
				crc_d  = crc_new;
				idx_d  = idx_q + 4'd1;
			end else begin
				// CRC byte closes the frame
				active_d = 1'b0;
				idx_d    = '0;
				crc_d    = '0;
				emit     = 1'b1;
				if (crc_q == item.data_byte) begin
					status = STATUS_OK;
					if (frame_kind) begin
						prior_d  = temp_q;
						temp_d   = {buf_q[1], buf_q[0]};
						config_d = buf_q[4];
					end else begin
						family_d = buf_q[0];
						serial_d = {buf_q[6], buf_q[5], buf_q[4],
							buf_q[3], buf_q[2], buf_q[1]};
					end
				end else begin
					status = STATUS_CRC_ERR;
					fail_d = fail_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			idx_q    <= '0;
			active_q <= 1'b0;
			family_q <= '0;
			serial_q <= '0;
			config_q <= '0;
			temp_q   <= '0;
			prior_q  <= '0;
			fail_q   <= '0;
		end else if (step) begin
			crc_q    <= crc_d;
			idx_q    <= idx_d;
			active_q <= active_d;
			family_q <= family_d;
			serial_q <= serial_d;
			config_q <= config_d;
			temp_q   <= temp_d;
			prior_q  <= prior_d;
			fail_q   <= fail_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && buf_wr) begin
			buf_q[idx_q[2:0]] <= item.data_byte;
		end
	end

	always_comb begin
		res.valid                     = emit;
		res.item.status               = status;
		res.item.dev_family           = family_d;
		res.item.dev_serial           = serial_d;
		res.item.temperature_raw      = signed'(temp_d);
		res.item.previous_temperature = signed'(prior_d);
		res.item.resolution_config    = config_d;
		res.item.crc_errors           = fail_d;
	end

endmodule

### design/onewire_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// onewire_frame_crc_checker
// Throughput: one request per cycle while out_ready does not stall the
// result register; input register, one pass of frame logic (byte CRC
// over eight bit steps), then the result register.
// Reset clears frame state, stored values and the fail count and sets
// frame_kind to scratchpad; the byte buffer is not cleared.
// ----------------------------------------------------------------------------
module onewire_frame_crc_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ofcc_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ofcc_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ofcc_pkg::out_item_t               out_item
);
	import ofcc_pkg::*;

	logic      frame_kind_q;
	reg_idx_t  reg_idx;
	logic      s1_valid_s1;
	in_item_t  item_s1;
	logic      advance;
	step_res_t res;
	logic      out_valid_q;
	out_item_t out_item_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1]);

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_KIND: prdata = {31'd0, frame_kind_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_kind_q <= 1'b1;
		end else if (psel && penable && pwrite && (reg_idx == REG_FRAME_KIND)) begin
			frame_kind_q <= pwdata[0];
		end
	end

	// input register; drains whenever the result register is free
	assign advance  = s1_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	ofcc_frame_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.frame_kind (frame_kind_q),
		.item       (item_s1),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_item_q <= res.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

### verif/onewire_frame_crc_checker_test.sv
// ----------------------------------------------------------------------------
// onewire_frame_crc_checker_test
// Drives bus-reset and byte requests into the 1-Wire frame checker, predicts
// each frame verdict with a CRC-8 model of its own, and checks every result
// field in order. A short table of directed requests is followed by phases
// of random frames under both frame kinds, with bursty input and a stalling
// output.
// ----------------------------------------------------------------------------
module onewire_frame_crc_checker_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ofcc_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE      = 8;
	localparam int PHASE_REQS  = 44;
	localparam int NUM_PHASES  = 8;
	localparam logic [PADDR_W-1:0] FRAME_KIND_ADDR = PADDR_W'(4 * REG_FRAME_KIND);

	typedef enum logic [1:0] {
		ROW_RESET,
		ROW_BYTE,
		ROW_CRC_GOOD,
		ROW_CRC_BAD
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [7:0] val;
		logic       typed;
		out_item_t  want;
	} stim_row_t;

	localparam out_item_t NO_DEV_AT_RESET = '{status: STATUS_NO_DEV, default: '0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b1;
	out_item_t   out_item;

	onewire_frame_crc_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// frame checker model state
	logic        fr_kind;
	logic [7:0]  fr_crc;
	logic [3:0]  fr_index;
	logic        fr_active;
	logic [7:0]  fr_buf [8];
	logic [7:0]  kept_family;
	logic [47:0] kept_serial;
	logic [7:0]  kept_config;
	logic signed [15:0] kept_temp;
	logic signed [15:0] kept_prior;
	logic [7:0]  kept_fails;

	out_item_t   verdicts_due [$];
	int          mismatches = 0;
	int          counted = 0;
	int          burst_left = 0;
	int          hold_seq = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          rx_tick = 0;
	int          rx_mode = 0;
	int          idle_cycles = 0;

	// all-zero scratchpad gives CRC 0; first row reads the reset values
	stim_row_t directed_rows [26] = '{
		'{ROW_RESET,    8'h00, 1'b1, NO_DEV_AT_RESET},
		'{ROW_BYTE,     8'hFF, 1'b0, '0},
		'{ROW_RESET,    8'h01, 1'b0, '0},
		'{ROW_BYTE,     8'h5A, 1'b0, '0},
		'{ROW_RESET,    8'h01, 1'b0, '0},
		'{ROW_BYTE,     8'hFF, 1'b0, '0},
		'{ROW_BYTE,     8'h7F, 1'b0, '0},
		'{ROW_BYTE,     8'h00, 1'b0, '0},
		'{ROW_BYTE,     8'h80, 1'b0, '0},
		'{ROW_BYTE,     8'hFF, 1'b0, '0},
		'{ROW_BYTE,     8'h00, 1'b0, '0},
		'{ROW_BYTE,     8'hFF, 1'b0, '0},
		'{ROW_BYTE,     8'h80, 1'b0, '0},
		'{ROW_CRC_GOOD, 8'h00, 1'b0, '0},
		'{ROW_BYTE,     8'hA5, 1'b0, '0},
		'{ROW_RESET,    8'h01, 1'b0, '0},
		'{ROW_BYTE,     8'h00, 1'b0, '0},
		'{ROW_BYTE,     8'h80, 1'b0, '0},
		'{ROW_BYTE,     8'h00, 1'b0, '0},
		'{ROW_BYTE,     8'h00, 1'b0, '0},
		'{ROW_BYTE,     8'h00, 1'b0, '0},
		'{ROW_BYTE,     8'h00, 1'b0, '0},
		'{ROW_BYTE,     8'h00, 1'b0, '0},
		'{ROW_BYTE,     8'h00, 1'b0, '0},
		'{ROW_CRC_BAD,  8'h01, 1'b0, '0},
		'{ROW_RESET,    8'h00, 1'b0, '0}
	};

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic logic [3:0] frame_len();
		return fr_kind ? PAD_LEN : ROM_LEN;
	endfunction

	function automatic out_item_t snapshot(status_t st);
		return '{status: st, dev_family: kept_family, dev_serial: kept_serial,
			temperature_raw: kept_temp, previous_temperature: kept_prior,
			resolution_config: kept_config, crc_errors: kept_fails};
	endfunction

	task automatic clear_model();
		fr_kind = 1'b1;
		fr_crc = '0;
		fr_index = '0;
		fr_active = 1'b0;
		kept_family = '0;
		kept_serial = '0;
		kept_config = '0;
		kept_temp = '0;
		kept_prior = '0;
		kept_fails = '0;
	endtask

	// taken is low for a byte that arrives with no frame open
	task automatic predict_frame(input in_item_t req, output bit taken, output bit has_res,
			output out_item_t res);
		taken = 1'b1;
		has_res = 1'b0;
		res = '0;
		if (req.cmd == CMD_BUS_RESET) begin
			fr_crc = '0;
			fr_index = '0;
			if (req.present) begin
				fr_active = 1'b1;
			end else begin
				fr_active = 1'b0;
				has_res = 1'b1;
				res = snapshot(STATUS_NO_DEV);
			end
		end else if (!fr_active) begin
			taken = 1'b0;
		end else if (fr_index < frame_len()) begin
			fr_buf[fr_index[2:0]] = req.data_byte;
			fr_crc = crc8_step(fr_crc, req.data_byte);
			fr_index = fr_index + 4'd1;
		end else begin
			fr_active = 1'b0;
			fr_index = '0;
			has_res = 1'b1;
			if (fr_crc == req.data_byte) begin
				if (fr_kind) begin
					kept_prior = kept_temp;
					kept_temp = {fr_buf[1], fr_buf[0]};
					kept_config = fr_buf[4];
				end else begin
					kept_family = fr_buf[0];
					kept_serial = {fr_buf[6], fr_buf[5], fr_buf[4],
						fr_buf[3], fr_buf[2], fr_buf[1]};
				end
				res = snapshot(STATUS_OK);
			end else begin
				kept_fails = kept_fails + 8'd1;
				res = snapshot(STATUS_CRC_ERR);
			end
			fr_crc = '0;
		end
	endtask

	// offer one request, honouring the burst/gap pattern; called at a clock edge
	task automatic offer(input in_item_t req, input bit use_typed, input out_item_t typed);
		bit taken;
		bit has_res;
		out_item_t res;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		in_item <= req;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		predict_frame(req, taken, has_res, res);
		if (has_res)
			verdicts_due.push_back(use_typed ? typed : res);
		if (taken)
			counted++;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_byte(logic [7:0] b);
		offer('{cmd: CMD_DATA, data_byte: b, present: 1'b0}, 1'b0, '0);
	endtask

	task automatic send_bus_reset(logic p);
		offer('{cmd: CMD_BUS_RESET, data_byte: rand_byte(), present: p}, 1'b0, '0);
	endtask

	// fill the open frame up to its length, then a good or corrupted CRC byte
	task automatic finish_frame();
		while (fr_active && fr_index < frame_len())
			send_byte(rand_byte());
		if (fr_active) begin
			if ($urandom_range(0, 9) < 7)
				send_byte(fr_crc);
			else
				send_byte(fr_crc ^ 8'($urandom_range(1, 255)));
		end
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	// frame_kind is only changed once the pipeline is empty
	task automatic set_frame_kind(logic kind);
		pause_until_drained();
		repeat (SETTLE) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= FRAME_KIND_ADDR;
		pwdata <= 32'(kind);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		fr_kind = kind;
	endtask

	task automatic field_check(string name, logic [47:0] want, logic [47:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_verdict(out_item_t got);
		out_item_t want;
		if (verdicts_due.size() == 0) begin
			$error("result with nothing outstanding: status %0d", got.status);
			mismatches++;
			return;
		end
		want = verdicts_due.pop_front();
		field_check("status", 48'(want.status), 48'(got.status));
		field_check("dev_family", 48'(want.dev_family), 48'(got.dev_family));
		field_check("dev_serial", want.dev_serial, got.dev_serial);
		field_check("temperature_raw", 48'(want.temperature_raw), 48'(got.temperature_raw));
		field_check("previous_temperature", 48'(want.previous_temperature),
			48'(got.previous_temperature));
		field_check("resolution_config", 48'(want.resolution_config),
			48'(got.resolution_config));
		field_check("crc_errors", 48'(want.crc_errors), 48'(got.crc_errors));
	endtask

	// receiver: own stall pattern, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_verdict(out_item);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			rx_tick++;
			if (rx_tick % 64 == 0)
				rx_mode = $urandom_range(0, 2);
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 9) < 6);
					default: out_ready <= (rx_tick % 5 < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		in_item_t  req;
		int        goal;
		bit        paused;
		clear_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_frame_kind(1'b1);
		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			case (row.kind)
				ROW_RESET: req = '{cmd: CMD_BUS_RESET, data_byte: 8'h00, present: row.val[0]};
				ROW_BYTE: req = '{cmd: CMD_DATA, data_byte: row.val, present: 1'b0};
				ROW_CRC_GOOD: req = '{cmd: CMD_DATA, data_byte: fr_crc, present: 1'b0};
				default: req = '{cmd: CMD_DATA, data_byte: fr_crc ^ row.val, present: 1'b0};
			endcase
			offer(req, row.typed, row.want);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_frame_kind(ph < 4 ? logic'(ph % 2) : logic'($urandom_range(0, 1)));
			if (ph == 2)
				hold_seq++;
			// a frame left open by the last phase now runs at the new length
			finish_frame();
			goal = counted + PHASE_REQS;
			paused = 1'b0;
			while (counted < goal) begin
				if (ph == 3 && !paused && counted >= goal - PHASE_REQS / 2) begin
					pause_until_drained();
					paused = 1'b1;
				end
				case ($urandom_range(0, 99)) inside
					[0:69]: begin
						send_bus_reset(1'b1);
						finish_frame();
					end
					[70:79]: begin
						send_bus_reset(1'b1);
						repeat ($urandom_range(0, 7)) send_byte(rand_byte());
					end
					[80:87]: send_bus_reset(1'b0);
					default: begin
						repeat ($urandom_range(1, 3))
							offer('{cmd: logic'($urandom_range(0, 1)), data_byte: rand_byte(),
								present: logic'($urandom_range(0, 1))}, 1'b0, '0);
					end
				endcase
			end
			if ($urandom_range(0, 1)) begin
				send_bus_reset(1'b1);
				repeat ($urandom_range(0, 7)) send_byte(rand_byte());
			end
		end

		pause_until_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
